// ===== design/sa_pkg.sv =====
// Shared types, widths and codes for the stack allocator.
`default_nettype none

package sa_pkg;

   localparam int ADDR_W     = 48;
   localparam int SIZE_W     = 25;
   localparam int OFF_W      = 24;
   localparam int ALIGN_W    = 13;
   localparam int LG_W       = 5;
   localparam int PAD_W      = 12;
   localparam int ALU_W      = 50;
   localparam int REQ_W      = 26;
   localparam int SMALL_W    = 14;
   localparam int MAX_ALLOCS = 64;
   localparam int IDX_W      = $clog2(MAX_ALLOCS);
   localparam int DEPTH_W    = $clog2(MAX_ALLOCS + 1);
   localparam int HDR_BYTES  = 32;
   localparam int HDR_ALIGN  = 8;
   localparam int PRE_W      = $clog2(HDR_ALIGN);
   localparam int CSR_IDX_W  = 1;

   localparam logic [1:0] ACT_ALLOC = 2'd0;
   localparam logic [1:0] ACT_FREE  = 2'd1;
   localparam logic [1:0] ACT_RESET = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 1'b1;

   localparam logic [SIZE_W-1:0] CAPACITY_RESET = SIZE_W'(24'hFF_FFFF) + 1'b1;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_ZERO_SIZE    = 3'd1,
      ST_BAD_ALIGN    = 3'd2,
      ST_NO_SPACE     = 3'd3,
      ST_OUT_OF_RANGE = 3'd4,
      ST_NOT_RECENT   = 3'd5,
      ST_STACK_FULL   = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [SIZE_W-1:0]  request_size;
      logic [ALIGN_W-1:0] request_alignment;
      logic [ADDR_W-1:0]  release_address;
   } req_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0] user_address;
      status_type        status;
   } rsp_payload_type;

   typedef struct packed {
      logic [SIZE_W-1:0] prev_used;
      logic [OFF_W-1:0]  prev_top;
      logic [LG_W-1:0]   align_log2;
   } hdr_entry_type;

   typedef struct packed {
      logic             sub;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic             borrow;
      logic [ALU_W-1:0] sum;
   } alu_rsp_type;

endpackage

`default_nettype wire

// ===== design/sa_alu.sv =====
// Shared add/subtract unit; borrow flags a < b on subtraction.
`default_nettype none

module sa_alu (
   input  wire sa_pkg::alu_req_type op,
   output sa_pkg::alu_rsp_type      res
);

   logic [sa_pkg::ALU_W:0] full;

   always_comb begin
      if (op.sub) begin
         full = {1'b0, op.a} - {1'b0, op.b};
      end else begin
         full = {1'b0, op.a} + {1'b0, op.b};
      end
      res.borrow = op.sub & full[sa_pkg::ALU_W];
      res.sum    = full[sa_pkg::ALU_W-1:0];
   end

endmodule

`default_nettype wire

// ===== design/sa_hdr_mem.sv =====
// Header stack memory: one write port, one registered read port.
`default_nettype none

module sa_hdr_mem (
   input  wire                            clock,
   input  wire                            wr_en,
   input  wire [sa_pkg::IDX_W-1:0]        wr_addr,
   input  wire sa_pkg::hdr_entry_type     wr_data,
   input  wire [sa_pkg::IDX_W-1:0]        rd_addr,
   output sa_pkg::hdr_entry_type          rd_data
);

   sa_pkg::hdr_entry_type mem [sa_pkg::MAX_ALLOCS];
   sa_pkg::hdr_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/stack_allocator.sv =====
// Top level of the stack allocator: sequencer around one shared adder.
//
//   channel   direction  handshake             contents
//   req_*     in         req_valid/req_ready   action, size, alignment, address
//   rsp_*     out        rsp_valid/rsp_ready   user address, status
//   csr_*     in         csr_we                base address (0), capacity (1)
//
// A request holds the block from transfer to next possible transfer. One rejected at
// once (zero size, bad alignment, full stack, null or empty free, reset action) goes
// straight to S_RESP, others through the S_A_* (allocate) or S_F_* (free) states. The
// result rises with req_ready. Every wide add and less-than compare uses the shared adder.
// Reset is synchronous; it empties the stack and restores the default registers.
// The next request is taken while a result still waits for rsp_ready.
`default_nettype none

module stack_allocator (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire sa_pkg::req_payload_type      req_payload,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output sa_pkg::rsp_payload_type           rsp_payload,
   input  wire                               csr_we,
   input  wire [sa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [sa_pkg::ADDR_W-1:0]          csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE, S_A_CUR, S_A_HDR, S_A_USER, S_A_REQ, S_A_ROOM, S_A_FIT, S_A_TOP,
      S_A_USED, S_F_LO, S_F_LOCHK, S_F_HI, S_F_HICHK, S_F_HDR, S_F_HDR32,
      S_F_EXP, S_RESP
   } state_type;

   state_type                       state_ff, state_in;
   logic [sa_pkg::ADDR_W-1:0]       base_ff, base_in;
   logic [sa_pkg::SIZE_W-1:0]       cap_ff, cap_in;
   logic [sa_pkg::SIZE_W-1:0]       used_ff, used_in;
   logic [sa_pkg::OFF_W-1:0]        top_ff, top_in;
   logic [sa_pkg::DEPTH_W-1:0]      depth_ff, depth_in;
   logic [sa_pkg::SIZE_W-1:0]       size_ff, size_in;
   logic [sa_pkg::PAD_W-1:0]        amask_ff, amask_in;
   logic [sa_pkg::LG_W-1:0]         lg_ff, lg_in;
   logic [sa_pkg::ADDR_W-1:0]       addr_ff, addr_in;
   logic [sa_pkg::PRE_W-1:0]        pre_ff, pre_in;
   logic [sa_pkg::PAD_W-1:0]        upad_ff, upad_in;
   logic [sa_pkg::ALU_W-1:0]        t_ff, t_in;
   logic [sa_pkg::ADDR_W-1:0]       user_ff, user_in;
   logic [sa_pkg::REQ_W-1:0]        req_ff, req_in;
   logic [sa_pkg::SIZE_W-1:0]       room_ff, room_in;
   logic [sa_pkg::ADDR_W-1:0]       res_addr_ff, res_addr_in;
   sa_pkg::status_type              res_status_ff, res_status_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   sa_pkg::rsp_payload_type         rsp_payload_ff, rsp_payload_in;

   sa_pkg::alu_req_type             alu_op;
   sa_pkg::alu_rsp_type             alu_res;
   logic                            hdr_we;
   sa_pkg::hdr_entry_type           hdr_wdata;
   sa_pkg::hdr_entry_type           hdr_rdata;
   logic [sa_pkg::IDX_W-1:0]        hdr_rd_idx;

   logic                            req_fire;
   logic                            align_pow2;
   logic [sa_pkg::LG_W-1:0]         align_lg;
   logic [sa_pkg::PAD_W-1:0]        free_mask;
   logic [sa_pkg::SMALL_W-1:0]      pre_hdr;
   logic [sa_pkg::SMALL_W-1:0]      overhead;

   sa_alu u_alu (
      .op  (alu_op),
      .res (alu_res)
   );

   sa_hdr_mem u_hdr_mem (
      .clock   (clock),
      .wr_en   (hdr_we),
      .wr_addr (sa_pkg::IDX_W'(depth_ff)),
      .wr_data (hdr_wdata),
      .rd_addr (hdr_rd_idx),
      .rd_data (hdr_rdata)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign req_fire    = req_valid & req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   // Top entry is read continuously; depth holds steady through a free.
   assign hdr_rd_idx  = sa_pkg::IDX_W'(depth_ff - 1'b1);

   always_comb begin
      align_pow2 = (req_payload.request_alignment != '0) &&
                   ((req_payload.request_alignment &
                     (req_payload.request_alignment - 1'b1)) == '0);
      align_lg = '0;
      for (int i = 0; i < sa_pkg::ALIGN_W; i++) begin
         if (req_payload.request_alignment[i]) begin
            align_lg = sa_pkg::LG_W'(i);
         end
      end
      for (int j = 0; j < sa_pkg::PAD_W; j++) begin
         free_mask[j] = (sa_pkg::LG_W'(j) < hdr_rdata.align_log2);
      end
      pre_hdr  = sa_pkg::SMALL_W'(pre_ff) + sa_pkg::SMALL_W'(sa_pkg::HDR_BYTES);
      overhead = pre_hdr + sa_pkg::SMALL_W'(upad_ff);
   end

   always_comb begin
      state_in       = state_ff;
      base_in        = base_ff;
      cap_in         = cap_ff;
      used_in        = used_ff;
      top_in         = top_ff;
      depth_in       = depth_ff;
      size_in        = size_ff;
      amask_in       = amask_ff;
      lg_in          = lg_ff;
      addr_in        = addr_ff;
      pre_in         = pre_ff;
      upad_in        = upad_ff;
      t_in           = t_ff;
      user_in        = user_ff;
      req_in         = req_ff;
      room_in        = room_ff;
      res_addr_in    = res_addr_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      alu_op         = '0;
      hdr_we         = 1'b0;
      hdr_wdata      = '{prev_used: used_ff, prev_top: top_ff, align_log2: lg_ff};

      if (csr_we) begin
         unique case (csr_index)
            sa_pkg::CSR_BASE:     base_in = csr_wdata;
            sa_pkg::CSR_CAPACITY: cap_in  = csr_wdata[sa_pkg::SIZE_W-1:0];
            default:              ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               size_in       = req_payload.request_size;
               amask_in      = sa_pkg::PAD_W'(req_payload.request_alignment - 1'b1);
               lg_in         = align_lg;
               addr_in       = req_payload.release_address;
               res_addr_in   = '0;
               res_status_in = sa_pkg::ST_OK;
               state_in      = S_RESP;
               case (req_payload.action)
                  sa_pkg::ACT_ALLOC: begin
                     if (req_payload.request_size == '0) begin
                        res_status_in = sa_pkg::ST_ZERO_SIZE;
                     end else if (!align_pow2) begin
                        res_status_in = sa_pkg::ST_BAD_ALIGN;
                     end else if (depth_ff == sa_pkg::DEPTH_W'(sa_pkg::MAX_ALLOCS)) begin
                        res_status_in = sa_pkg::ST_STACK_FULL;
                     end else begin
                        state_in = S_A_CUR;
                     end
                  end
                  sa_pkg::ACT_FREE: begin
                     if (req_payload.release_address == '0) begin
                        res_status_in = sa_pkg::ST_OK;
                     end else if (depth_ff == '0) begin
                        res_status_in = sa_pkg::ST_OUT_OF_RANGE;
                     end else begin
                        state_in = S_F_LO;
                     end
                  end
                  sa_pkg::ACT_RESET: begin
                     used_in  = '0;
                     top_in   = '0;
                     depth_in = '0;
                  end
                  default: ;
               endcase
            end
         end

         S_A_CUR: begin
            alu_op   = '{sub: 1'b0, a: sa_pkg::ALU_W'(base_ff), b: sa_pkg::ALU_W'(used_ff)};
            t_in     = alu_res.sum;
            pre_in   = sa_pkg::PRE_W'(0) - alu_res.sum[sa_pkg::PRE_W-1:0];
            state_in = S_A_HDR;
         end

         S_A_HDR: begin
            alu_op   = '{sub: 1'b0, a: t_ff, b: sa_pkg::ALU_W'(pre_hdr)};
            t_in     = alu_res.sum;
            upad_in  = (sa_pkg::PAD_W'(0) - alu_res.sum[sa_pkg::PAD_W-1:0]) & amask_ff;
            state_in = S_A_USER;
         end

         S_A_USER: begin
            alu_op   = '{sub: 1'b0, a: t_ff, b: sa_pkg::ALU_W'(upad_ff)};
            user_in  = alu_res.sum[sa_pkg::ADDR_W-1:0];
            state_in = S_A_REQ;
         end

         S_A_REQ: begin
            alu_op   = '{sub: 1'b0, a: sa_pkg::ALU_W'(size_ff), b: sa_pkg::ALU_W'(overhead)};
            req_in   = alu_res.sum[sa_pkg::REQ_W-1:0];
            state_in = S_A_ROOM;
         end

         S_A_ROOM: begin
            // Borrow here means capacity was lowered below what is in use.
            alu_op  = '{sub: 1'b1, a: sa_pkg::ALU_W'(cap_ff), b: sa_pkg::ALU_W'(used_ff)};
            room_in = alu_res.sum[sa_pkg::SIZE_W-1:0];
            if (alu_res.borrow) begin
               res_status_in = sa_pkg::ST_NO_SPACE;
               state_in      = S_RESP;
            end else begin
               state_in = S_A_FIT;
            end
         end

         S_A_FIT: begin
            alu_op = '{sub: 1'b1, a: sa_pkg::ALU_W'(room_ff), b: sa_pkg::ALU_W'(req_ff)};
            if (alu_res.borrow) begin
               res_status_in = sa_pkg::ST_NO_SPACE;
               state_in      = S_RESP;
            end else begin
               state_in = S_A_TOP;
            end
         end

         S_A_TOP: begin
            // Push the old top before it is replaced.
            alu_op   = '{sub: 1'b0, a: sa_pkg::ALU_W'(used_ff), b: sa_pkg::ALU_W'(pre_ff)};
            hdr_we   = 1'b1;
            top_in   = alu_res.sum[sa_pkg::OFF_W-1:0];
            state_in = S_A_USED;
         end

         S_A_USED: begin
            alu_op        = '{sub: 1'b0, a: sa_pkg::ALU_W'(used_ff), b: sa_pkg::ALU_W'(req_ff)};
            used_in       = alu_res.sum[sa_pkg::SIZE_W-1:0];
            depth_in      = depth_ff + 1'b1;
            res_addr_in   = user_ff;
            res_status_in = sa_pkg::ST_OK;
            state_in      = S_RESP;
         end

         S_F_LO: begin
            alu_op   = '{sub: 1'b0, a: sa_pkg::ALU_W'(base_ff),
                         b: sa_pkg::ALU_W'(sa_pkg::HDR_BYTES)};
            t_in     = alu_res.sum;
            state_in = S_F_LOCHK;
         end

         S_F_LOCHK: begin
            alu_op = '{sub: 1'b1, a: sa_pkg::ALU_W'(addr_ff), b: t_ff};
            if (alu_res.borrow) begin
               res_status_in = sa_pkg::ST_OUT_OF_RANGE;
               state_in      = S_RESP;
            end else begin
               state_in = S_F_HI;
            end
         end

         S_F_HI: begin
            alu_op   = '{sub: 1'b0, a: sa_pkg::ALU_W'(base_ff), b: sa_pkg::ALU_W'(used_ff)};
            t_in     = alu_res.sum;
            state_in = S_F_HICHK;
         end

         S_F_HICHK: begin
            alu_op = '{sub: 1'b1, a: sa_pkg::ALU_W'(addr_ff), b: t_ff};
            if (!alu_res.borrow) begin
               res_status_in = sa_pkg::ST_OUT_OF_RANGE;
               state_in      = S_RESP;
            end else begin
               state_in = S_F_HDR;
            end
         end

         S_F_HDR: begin
            alu_op   = '{sub: 1'b0, a: sa_pkg::ALU_W'(base_ff), b: sa_pkg::ALU_W'(top_ff)};
            t_in     = alu_res.sum;
            state_in = S_F_HDR32;
         end

         S_F_HDR32: begin
            alu_op   = '{sub: 1'b0, a: t_ff, b: sa_pkg::ALU_W'(sa_pkg::HDR_BYTES)};
            t_in     = alu_res.sum;
            upad_in  = (sa_pkg::PAD_W'(0) - alu_res.sum[sa_pkg::PAD_W-1:0]) & free_mask;
            state_in = S_F_EXP;
         end

         S_F_EXP: begin
            alu_op   = '{sub: 1'b0, a: t_ff, b: sa_pkg::ALU_W'(upad_ff)};
            state_in = S_RESP;
            if (alu_res.sum != sa_pkg::ALU_W'(addr_ff)) begin
               res_status_in = sa_pkg::ST_NOT_RECENT;
            end else begin
               // Pop: restore the top from before the newest allocate.
               used_in       = hdr_rdata.prev_used;
               top_in        = hdr_rdata.prev_top;
               depth_in      = depth_ff - 1'b1;
               res_status_in = sa_pkg::ST_OK;
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = '{user_address: res_addr_ff, status: res_status_ff};
               state_in       = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         cap_ff       <= sa_pkg::CAPACITY_RESET;
         used_ff      <= '0;
         top_ff       <= '0;
         depth_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         cap_ff       <= cap_in;
         used_ff      <= used_in;
         top_ff       <= top_in;
         depth_ff     <= depth_in;
      end
      size_ff        <= size_in;
      amask_ff       <= amask_in;
      lg_ff          <= lg_in;
      addr_ff        <= addr_in;
      pre_ff         <= pre_in;
      upad_ff        <= upad_in;
      t_ff           <= t_in;
      user_ff        <= user_in;
      req_ff         <= req_in;
      room_ff        <= room_in;
      res_addr_ff    <= res_addr_in;
      res_status_ff  <= res_status_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request taken while the previous one is still in progress");

   a_depth_step: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (depth_ff == $past(depth_ff)) ||
                 (depth_ff == $past(depth_ff) + 1'b1) ||
                 (depth_ff + 1'b1 == $past(depth_ff)) ||
                 (depth_ff == '0))
      else $error("stack depth moved by more than one entry");

   a_push_in_bounds: assert property (@(posedge clock) disable iff (reset)
      hdr_we |-> (depth_ff < sa_pkg::DEPTH_W'(sa_pkg::MAX_ALLOCS)))
      else $error("header push on a full stack");

   a_fail_no_address: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_A_USED) |=> (res_addr_ff == $past(user_ff)))
      else $error("allocate result lost its user address");

endmodule

`default_nettype wire

// ===== sim/tb_stack_allocator.sv =====
// Self-checking testbench for the stack allocator: directed and random traffic against an in-order predictor.
`timescale 1ns / 100ps

module tb_stack_allocator;

   localparam logic [1:0] ACT_NONE = 2'd3;
   localparam int STALL_LIMIT     = 4000;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 12;

   logic                         clock;
   logic                         reset       = 1'b1;
   logic                         req_valid   = 1'b0;
   logic                         req_ready;
   sa_pkg::req_payload_type      req_payload = '0;
   logic                         rsp_valid;
   logic                         rsp_ready   = 1'b0;
   sa_pkg::rsp_payload_type      rsp_payload;
   logic                         csr_we      = 1'b0;
   logic [sa_pkg::CSR_IDX_W-1:0] csr_index   = sa_pkg::CSR_BASE;
   logic [sa_pkg::ADDR_W-1:0]    csr_wdata   = '0;

   // Allocator state as the predictor sees it
   logic [sa_pkg::ADDR_W-1:0] region_base = '0;
   logic [sa_pkg::SIZE_W-1:0] region_cap  = sa_pkg::CAPACITY_RESET;
   logic [sa_pkg::SIZE_W-1:0] fill_level  = '0;
   logic [sa_pkg::OFF_W-1:0]  top_hdr_off = '0;
   sa_pkg::hdr_entry_type     hdr_saves[$];
   logic [sa_pkg::ADDR_W-1:0] live_users[$];

   sa_pkg::req_payload_type queued_requests[$];
   sa_pkg::rsp_payload_type due_replies[$];
   sa_pkg::rsp_payload_type due_head;

   logic req_accepted  = 1'b0;
   int   send_idle_pct = 0;
   int   rsp_idle_pct  = 0;
   int   hold_asked    = 0;
   int   hold_served   = 0;
   int   hold_left     = 0;
   int   quiet_cycles  = 0;
   int   fail_count    = 0;
   int   reply_count   = 0;

   stack_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Apply one request to the predicted state and return the reply it must produce
   function automatic sa_pkg::rsp_payload_type step_allocator(
         input sa_pkg::req_payload_type rq);
      sa_pkg::rsp_payload_type rs;
      sa_pkg::hdr_entry_type   saved;
      logic [63:0]             cur, pre, hdr, upad, need, mask, want;
      int unsigned             lg;
      rs.user_address = '0;
      rs.status       = sa_pkg::ST_OK;
      case (rq.action)
         sa_pkg::ACT_ALLOC: begin
            if (rq.request_size == 0) begin
               rs.status = sa_pkg::ST_ZERO_SIZE;
            end else if (rq.request_alignment == 0 ||
                         (rq.request_alignment & (rq.request_alignment - 1'b1)) != 0) begin
               rs.status = sa_pkg::ST_BAD_ALIGN;
            end else if (hdr_saves.size() >= sa_pkg::MAX_ALLOCS) begin
               rs.status = sa_pkg::ST_STACK_FULL;
            end else begin
               lg = 0;
               while ((sa_pkg::ALIGN_W'(1) << lg) != rq.request_alignment) lg++;
               mask = 64'(rq.request_alignment) - 64'd1;
               cur  = 64'(region_base) + 64'(fill_level);
               pre  = (64'(sa_pkg::HDR_ALIGN) - cur % 64'(sa_pkg::HDR_ALIGN)) %
                      64'(sa_pkg::HDR_ALIGN);
               hdr  = cur + pre;
               upad = (64'd0 - (hdr + 64'(sa_pkg::HDR_BYTES))) & mask;
               need = pre + 64'(sa_pkg::HDR_BYTES) + upad + 64'(rq.request_size);
               if (64'(fill_level) > 64'(region_cap) ||
                   need > 64'(region_cap) - 64'(fill_level)) begin
                  rs.status = sa_pkg::ST_NO_SPACE;
               end else begin
                  saved.prev_used  = fill_level;
                  saved.prev_top   = top_hdr_off;
                  saved.align_log2 = sa_pkg::LG_W'(lg);
                  hdr_saves.push_back(saved);
                  top_hdr_off     = sa_pkg::OFF_W'(64'(fill_level) + pre);
                  fill_level      = sa_pkg::SIZE_W'(64'(fill_level) + need);
                  // user address wraps at the top of the address space
                  rs.user_address = sa_pkg::ADDR_W'(hdr + 64'(sa_pkg::HDR_BYTES) + upad);
                  live_users.push_back(rs.user_address);
               end
            end
         end
         sa_pkg::ACT_FREE: begin
            if (rq.release_address == 0) begin
               rs.status = sa_pkg::ST_OK;
            end else if (hdr_saves.size() == 0 ||
                         64'(rq.release_address) <
                            64'(region_base) + 64'(sa_pkg::HDR_BYTES) ||
                         64'(rq.release_address) >=
                            64'(region_base) + 64'(fill_level)) begin
               rs.status = sa_pkg::ST_OUT_OF_RANGE;
            end else begin
               saved = hdr_saves[hdr_saves.size() - 1];
               hdr   = 64'(region_base) + 64'(top_hdr_off) + 64'(sa_pkg::HDR_BYTES);
               want  = hdr + ((64'd0 - hdr) & ((64'd1 << saved.align_log2) - 64'd1));
               if (64'(rq.release_address) != want) begin
                  rs.status = sa_pkg::ST_NOT_RECENT;
               end else begin
                  fill_level  = saved.prev_used;
                  top_hdr_off = saved.prev_top;
                  void'(hdr_saves.pop_back());
                  void'(live_users.pop_back());
               end
            end
         end
         sa_pkg::ACT_RESET: begin
            fill_level  = '0;
            top_hdr_off = '0;
            hdr_saves.delete();
            live_users.delete();
         end
         default: ;
      endcase
      return rs;
   endfunction

   task automatic queue_request(input logic [1:0] action,
                                input logic [sa_pkg::SIZE_W-1:0] size,
                                input logic [sa_pkg::ALIGN_W-1:0] align,
                                input logic [sa_pkg::ADDR_W-1:0] addr);
      sa_pkg::req_payload_type rq;
      rq.action            = action;
      rq.request_size      = size;
      rq.request_alignment = align;
      rq.release_address   = addr;
      due_replies.push_back(step_allocator(rq));
      queued_requests.push_back(rq);
   endtask

   task automatic queue_random_request();
      int                         pick;
      logic [sa_pkg::SIZE_W-1:0]  sz;
      logic [sa_pkg::ALIGN_W-1:0] al;
      logic [sa_pkg::ADDR_W-1:0]  addr, target;
      pick = $urandom_range(99);
      sz   = sa_pkg::SIZE_W'($urandom_range(1 << 24));
      al   = sa_pkg::ALIGN_W'($urandom_range(4096));
      addr = sa_pkg::ADDR_W'({$urandom(), $urandom()});
      if (pick < 40) begin
         case ($urandom_range(19))
            0:       sz = sa_pkg::SIZE_W'($urandom_range(1 << 24, 1));
            1, 2:    sz = sa_pkg::SIZE_W'($urandom_range(65536, 1));
            3, 4, 5: sz = sa_pkg::SIZE_W'($urandom_range(4096, 1));
            default: sz = sa_pkg::SIZE_W'($urandom_range(64, 1));
         endcase
         queue_request(sa_pkg::ACT_ALLOC, sz, sa_pkg::ALIGN_W'(1) << $urandom_range(12), addr);
      end else if (pick < 82) begin
         if (live_users.size() == 0) begin
            target = ($urandom_range(1) != 0) ? '0 : addr;
         end else begin
            target = live_users[live_users.size() - 1];
            case ($urandom_range(9))
               6: target = '0;
               7: target = live_users[$urandom_range(live_users.size() - 1)];
               8: target = target + sa_pkg::ADDR_W'($urandom_range(8, 1));
               9: target = addr;
               default: ;
            endcase
         end
         queue_request(sa_pkg::ACT_FREE, sz, al, target);
      end else if (pick < 84) begin
         queue_request(sa_pkg::ACT_RESET, sz, al, addr);
      end else if (pick < 88) begin
         queue_request(ACT_NONE, sz, al, addr);
      end else if ($urandom_range(1) != 0) begin
         queue_request(sa_pkg::ACT_ALLOC, '0, al, addr);
      end else begin
         queue_request(sa_pkg::ACT_ALLOC, sz, al, addr);
      end
   endtask

   task automatic wait_drained();
      while (due_replies.size() != 0) @(posedge clock);
   endtask

   // Registers change only with nothing in flight
   task automatic set_region(input logic [sa_pkg::ADDR_W-1:0] base,
                             input logic [sa_pkg::SIZE_W-1:0] cap);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= sa_pkg::CSR_BASE;
      csr_wdata <= base;
      @(negedge clock);
      csr_index <= sa_pkg::CSR_CAPACITY;
      csr_wdata <= sa_pkg::ADDR_W'(cap);
      @(negedge clock);
      csr_we      <= 1'b0;
      region_base  = base;
      region_cap   = cap;
   endtask

   // Request driver: hold payload until transfer, then advance or idle
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= queued_requests.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Reply side back-pressure, including the long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         rsp_ready   <= 1'b0;
         hold_left   <= RSP_HOLD_CYCLES;
         hold_served <= hold_asked;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Monitor, checker and watchdog
   always @(posedge clock) begin
      req_accepted <= req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (due_replies.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected reply %0d: user_address %h status %0d",
                           reply_count, rsp_payload.user_address, rsp_payload.status);
               fail_count++;
            end else begin
               due_head = due_replies.pop_front();
               if (rsp_payload.user_address !== due_head.user_address ||
                   rsp_payload.status !== due_head.status) begin
                  if (fail_count < 10)
                     $display("reply %0d: user_address %h, want %h; status %0d, want %0d",
                              reply_count, rsp_payload.user_address, due_head.user_address,
                              rsp_payload.status, due_head.status);
                  fail_count++;
               end
            end
            reply_count++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles == STALL_LIMIT) begin
            $display("[stack_allocator] ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase one: sender idles rarely, receiver often
      send_idle_pct = 11;
      rsp_idle_pct  = 81;
      set_region('0, sa_pkg::CAPACITY_RESET);
      queue_request(sa_pkg::ACT_ALLOC, '0, 13'd8, '0);
      queue_request(sa_pkg::ACT_ALLOC, '0, 13'd3, '0);
      queue_request(sa_pkg::ACT_ALLOC, 25'd16, '0, '0);
      queue_request(sa_pkg::ACT_ALLOC, 25'd16, 13'd12, '0);
      queue_request(sa_pkg::ACT_ALLOC, 25'd1, 13'd4095, '0);
      queue_request(sa_pkg::ACT_FREE, '0, '0, '0);
      queue_request(sa_pkg::ACT_FREE, '0, '0, 48'd64);
      queue_request(ACT_NONE, sa_pkg::SIZE_W'($urandom()), sa_pkg::ALIGN_W'($urandom()),
                    sa_pkg::ADDR_W'({$urandom(), $urandom()}));
      queue_request(sa_pkg::ACT_ALLOC, 25'd1, 13'd1, '0);
      queue_request(sa_pkg::ACT_ALLOC, 25'd100, 13'd4096, '0);
      queue_request(sa_pkg::ACT_FREE, '0, '0, 48'd32);
      queue_request(sa_pkg::ACT_FREE, '0, '0, 48'd8);
      queue_request(sa_pkg::ACT_FREE, '0, '0, '1);
      queue_request(sa_pkg::ACT_FREE, '0, '0, 48'd4096);
      queue_request(sa_pkg::ACT_FREE, '0, '0, 48'd32);
      queue_request(sa_pkg::ACT_ALLOC, 25'd16777216, 13'd4096, '0);
      // fills the region to the last byte
      queue_request(sa_pkg::ACT_ALLOC, 25'd16777184, 13'd1, '0);
      queue_request(sa_pkg::ACT_ALLOC, 25'd1, 13'd1, '0);
      queue_request(sa_pkg::ACT_RESET, '1, '1, '1);
      queue_request(sa_pkg::ACT_FREE, '0, '0, 48'd32);
      repeat (150) queue_random_request();
      // leave more in use than the next capacity allows
      queue_request(sa_pkg::ACT_RESET, '0, '0, '0);
      queue_request(sa_pkg::ACT_ALLOC, 25'd8192, 13'd1, '0);

      set_region(sa_pkg::ADDR_W'({$urandom(), $urandom()}) & ~sa_pkg::ADDR_W'(7), 25'd4096);
      repeat (250) queue_random_request();

      // Phase two: the other way round
      send_idle_pct = 81;
      rsp_idle_pct  = 11;
      set_region(48'hFFFF_FFFF_F000, sa_pkg::CAPACITY_RESET);
      repeat (250) queue_random_request();
      set_region('1, 25'd1);
      repeat (100) queue_random_request();

      // Phase three: no idling; fill the header stack past its limit, then unwind it
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      set_region(48'h0000_0012_3450, 25'd65536);
      queue_request(sa_pkg::ACT_RESET, '0, '0, '0);
      repeat (66)
         queue_request(sa_pkg::ACT_ALLOC, sa_pkg::SIZE_W'($urandom_range(16, 1)),
                       sa_pkg::ALIGN_W'(1) << $urandom_range(3), '0);
      repeat (66) begin
         if (live_users.size() != 0)
            queue_request(sa_pkg::ACT_FREE, '0, '0, live_users[live_users.size() - 1]);
         else
            queue_request(sa_pkg::ACT_FREE, '0, '0,
                          sa_pkg::ADDR_W'({$urandom(), $urandom()}));
      end
      wait_drained();
      repeat (350) queue_random_request();
      // stall the reply side while requests keep coming
      repeat (40) @(posedge clock);
      hold_asked++;

      wait_drained();
      repeat (SETTLE_CYCLES + 8) @(posedge clock);
      if (fail_count == 0 && due_replies.size() == 0)
         $display("[stack_allocator] OK");
      else
         $display("[stack_allocator] ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/sa_pkg.sv
design/sa_alu.sv
design/sa_hdr_mem.sv
design/stack_allocator.sv
sim/tb_stack_allocator.sv
